// File: hdl/isff_pkg.sv
// Package with the shared types and constants of the interval slot allocator.
package isff_pkg;

    localparam int TW = 17;

    typedef struct packed {
        logic [1:0]    req_type;
        logic [TW-1:0] start_time;
        logic [TW-1:0] end_time;
        logic [TW-1:0] duration;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]    status;
        logic          found;
        logic [TW-1:0] slot_start;
        logic [6:0]    position;
    } out_beat_t;

    typedef struct packed {
        logic [TW-1:0] start_time;
        logic [TW-1:0] end_time;
    } entry_t;

    localparam logic [1:0] REQ_INSERT   = 2'd0;
    localparam logic [1:0] REQ_REMOVE   = 2'd1;
    localparam logic [1:0] REQ_FIND     = 2'd2;
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [1:0] CFG_WIN_START = 2'd0;
    localparam logic [1:0] CFG_WIN_END   = 2'd1;
    localparam logic [1:0] CFG_MAX_TOTAL = 2'd2;

    localparam logic [1:0] CELL_HOLD  = 2'd0;
    localparam logic [1:0] CELL_RIGHT = 2'd1;
    localparam logic [1:0] CELL_LEFT  = 2'd2;
    localparam logic [1:0] CELL_NEW   = 2'd3;

endpackage

// File: hdl/isff_cell.sv
// One storage cell of the interval chain: holds one entry and loads from a neighbor or the new entry.
module isff_cell
    import isff_pkg::*;
(
    input  logic       clk,
    input  logic [1:0] mode,
    input  entry_t     left_entry,
    input  entry_t     right_entry,
    input  entry_t     new_entry,
    output entry_t     entry
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        case (mode)
            CELL_RIGHT: entry_next = right_entry;
            CELL_LEFT:  entry_next = left_entry;
            CELL_NEW:   entry_next = new_entry;
            default:    entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: hdl/interval_slot_first_fit_top.sv
// Top level of the interval slot allocator: controller and chain of entry cells.
// A new request is accepted only in the idle state, after the previous answer has been handed to the
// output register. Insert, remove and find requests walk the full rotation of the cell chain
// through the head cell, one entry a cycle; reserved request types skip the scan. Reset clears the
// entry count, the booked total and the control state, and loads the window and limit registers.
module interval_slot_first_fit_top
    import isff_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [TW-1:0] cfg_data,
    input  logic          in_valid,
    output logic          in_ready,
    input  in_beat_t      in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output out_beat_t     out_data
);

    localparam int KW = $clog2(MAX_ENTRIES + 1);
    localparam logic [KW-1:0] LAST_STEP = KW'(MAX_ENTRIES - 1);
    localparam logic [KW-1:0] FULL_COUNT = KW'(MAX_ENTRIES);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [KW-1:0] step_reg, step_next;
    logic [KW-1:0] count_reg, count_next;
    logic [KW-1:0] idx_reg, idx_next;
    logic          hit_reg, hit_next;
    logic [17:0]   cur_reg, cur_next;
    logic [17:0]   span_reg, span_next;
    logic [TW-1:0] total_reg, total_next;
    logic [TW-1:0] win_start_reg, win_end_reg, max_total_reg;
    in_beat_t      req_reg, req_next;
    out_beat_t     res_reg, res_next;
    out_beat_t     out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    entry_t        cell_q [MAX_ENTRIES];
    logic [1:0]    cell_mode [MAX_ENTRIES];
    entry_t        new_entry;
    entry_t        head;

    logic          in_take;
    logic          is_insert_ok;
    logic          is_remove_ok;
    logic          in_range;
    logic signed [18:0] gap;
    logic signed [18:0] tail;
    logic signed [18:0] dur_s;
    logic [17:0]   sum_add;
    logic [17:0]   head_span;
    logic [17:0]   req_span;
    logic [17:0]   refuse_sum;

    assign head = cell_q[0];
    assign new_entry = '{start_time: req_reg.start_time, end_time: req_reg.end_time};
    assign in_ready = (state_reg == S_IDLE);
    assign in_take = in_valid && in_ready;
    assign in_range = (step_reg < count_reg);
    assign is_insert_ok = (req_reg.req_type == REQ_INSERT) && (count_reg != FULL_COUNT);
    assign is_remove_ok = (req_reg.req_type == REQ_REMOVE) && hit_reg;

    assign dur_s = {2'b00, req_reg.duration};
    assign gap = $signed({2'b00, head.start_time}) - $signed({1'b0, cur_reg});
    assign tail = $signed({2'b00, win_end_reg}) - $signed({1'b0, cur_reg}) + 19'sd1;
    assign head_span = (head.end_time >= head.start_time) ?
                       ({1'b0, head.end_time} - {1'b0, head.start_time} + 18'd1) : '0;
    assign req_span = (req_reg.end_time >= req_reg.start_time) ?
                      ({1'b0, req_reg.end_time} - {1'b0, req_reg.start_time} + 18'd1) : '0;
    assign sum_add = {1'b0, total_reg} + req_span;
    assign refuse_sum = {1'b0, total_reg} + {1'b0, req_reg.duration};

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++)
        begin : g_cell
            always_comb
            begin
                cell_mode[gi] = CELL_HOLD;
                if (state_reg == S_SCAN)
                begin
                    cell_mode[gi] = CELL_RIGHT;
                end
                else if (state_reg == S_APPLY)
                begin
                    if (is_insert_ok)
                    begin
                        if (KW'(gi) > idx_reg)
                        begin
                            cell_mode[gi] = CELL_LEFT;
                        end
                        else if (KW'(gi) == idx_reg)
                        begin
                            cell_mode[gi] = CELL_NEW;
                        end
                    end
                    else if (is_remove_ok)
                    begin
                        if ((KW'(gi) >= idx_reg) && (KW'(gi + 1) < count_reg))
                        begin
                            cell_mode[gi] = CELL_RIGHT;
                        end
                    end
                end
            end

            isff_cell u_cell (
                .clk         (clk),
                .mode        (cell_mode[gi]),
                .left_entry  (cell_q[(gi + MAX_ENTRIES - 1) % MAX_ENTRIES]),
                .right_entry (cell_q[(gi + 1) % MAX_ENTRIES]),
                .new_entry   (new_entry),
                .entry       (cell_q[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        cur_next       = cur_reg;
        span_next      = span_reg;
        total_next     = total_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    req_next  = in_data;
                    step_next = '0;
                    hit_next  = 1'b0;
                    idx_next  = '0;
                    span_next = '0;
                    cur_next  = {1'b0, win_start_reg};
                    res_next  = '0;
                    if (in_data.req_type == REQ_INSERT || in_data.req_type == REQ_REMOVE ||
                        in_data.req_type == REQ_FIND)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                if (in_range && !hit_reg)
                begin
                    case (req_reg.req_type)
                        REQ_INSERT:
                        begin
                            if (!(req_reg.start_time > head.start_time))
                            begin
                                hit_next = 1'b1;
                                idx_next = step_reg;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (head.start_time == req_reg.start_time)
                            begin
                                hit_next  = 1'b1;
                                idx_next  = step_reg;
                                span_next = head_span;
                            end
                        end
                        REQ_FIND:
                        begin
                            if (gap >= dur_s)
                            begin
                                hit_next = 1'b1;
                            end
                            else
                            begin
                                cur_next = {1'b0, head.end_time} + 18'd1;
                            end
                        end
                        default:
                        begin
                            hit_next = hit_reg;
                        end
                    endcase
                end
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_APPLY;
                end
                else
                begin
                    step_next = step_reg + KW'(1);
                end
            end
            S_APPLY:
            begin
                res_next = '0;
                case (req_reg.req_type)
                    REQ_INSERT:
                    begin
                        if (count_reg == FULL_COUNT)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + KW'(1);
                            res_next.position = 7'(idx_reg);
                            total_next = sum_add[17] ? {TW{1'b1}} : sum_add[TW-1:0];
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (!hit_reg)
                        begin
                            res_next.status = ST_NOT_FOUND;
                        end
                        else
                        begin
                            count_next = count_reg - KW'(1);
                            res_next.position = 7'(idx_reg);
                            total_next = ({1'b0, total_reg} > span_reg) ?
                                         (total_reg - span_reg[TW-1:0]) : '0;
                        end
                    end
                    REQ_FIND:
                    begin
                        if (refuse_sum > {1'b0, max_total_reg})
                        begin
                            res_next.found = 1'b0;
                            res_next.slot_start = '0;
                        end
                        else
                        begin
                            res_next.found = hit_reg || (tail >= dur_s);
                            res_next.slot_start = cur_reg[TW-1:0];
                        end
                    end
                    default:
                    begin
                        res_next = '0;
                    end
                endcase
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (req_reg.req_type == REQ_INSERT && state_reg == S_SCAN && step_reg == LAST_STEP &&
            !hit_next)
        begin
            idx_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            win_start_reg <= TW'(0);
            win_end_reg   <= TW'(86399);
            max_total_reg <= TW'(86400);
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WIN_START: win_start_reg <= cfg_data;
                    CFG_WIN_END:   win_end_reg   <= cfg_data;
                    CFG_MAX_TOTAL: max_total_reg <= cfg_data;
                    default:       win_start_reg <= win_start_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        idx_reg  <= idx_next;
        hit_reg  <= hit_next;
        cur_reg  <= cur_next;
        span_reg <= span_next;
        req_reg  <= req_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: sim/tb_interval_slot_first_fit_top.sv
// Testbench for the interval slot allocator: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module tb_interval_slot_first_fit_top;
    import isff_pkg::*;

    localparam int ENTRIES = 64;
    localparam int CYCLE_LIMIT = 2000000;

    logic          clk;
    logic          rst_n;
    logic          cfg_we;
    logic [1:0]    cfg_index;
    logic [TW-1:0] cfg_data;
    logic          in_valid;
    logic          in_ready;
    in_beat_t      in_data;
    logic          out_valid;
    logic          out_ready;
    out_beat_t     out_data;

    interval_slot_first_fit_top #(.MAX_ENTRIES(ENTRIES)) dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
        .out_data(out_data)
    );

    logic [TW-1:0] win_lo, win_hi, total_cap;
    logic [TW-1:0] book_start [ENTRIES];
    logic [TW-1:0] book_end [ENTRIES];
    int            book_count;
    logic [TW-1:0] booked_sum;
    out_beat_t     pending_answers[$];
    int            errors;
    int            cycles;
    int            hold_off;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [TW:0] span(logic [TW-1:0] s, logic [TW-1:0] e);
        return (e >= s) ? ({1'b0, e} - {1'b0, s} + 18'd1) : '0;
    endfunction

    function automatic out_beat_t predict_answer(in_beat_t r);
        out_beat_t a;
        int        idx;
        int        sum;
        longint    cur;
        bit        done;
        a = '0;
        case (r.req_type)
            REQ_INSERT:
            begin
                if (book_count >= ENTRIES)
                begin
                    a.status = ST_FULL;
                end
                else
                begin
                    idx = 0;
                    while (idx < book_count && r.start_time > book_start[idx])
                        idx++;
                    for (int i = book_count; i > idx; i--)
                    begin
                        book_start[i] = book_start[i-1];
                        book_end[i] = book_end[i-1];
                    end
                    book_start[idx] = r.start_time;
                    book_end[idx] = r.end_time;
                    book_count++;
                    sum = booked_sum + span(r.start_time, r.end_time);
                    booked_sum = (sum > 131071) ? 17'h1FFFF : TW'(sum);
                    a.position = 7'(idx);
                end
            end
            REQ_REMOVE:
            begin
                idx = 0;
                while (idx < book_count && book_start[idx] != r.start_time)
                    idx++;
                if (idx >= book_count)
                begin
                    a.status = ST_NOT_FOUND;
                end
                else
                begin
                    sum = span(book_start[idx], book_end[idx]);
                    booked_sum = (booked_sum > sum) ? TW'(booked_sum - sum) : '0;
                    for (int i = idx; i + 1 < book_count; i++)
                    begin
                        book_start[i] = book_start[i+1];
                        book_end[i] = book_end[i+1];
                    end
                    book_count--;
                    a.position = 7'(idx);
                end
            end
            REQ_FIND:
            begin
                if (longint'(booked_sum) + r.duration <= longint'(total_cap))
                begin
                    cur = win_lo;
                    done = 0;
                    for (int i = 0; i < book_count && !done; i++)
                    begin
                        if (longint'(book_start[i]) - cur >= longint'(r.duration))
                            done = 1;
                        else
                            cur = longint'(book_end[i]) + 1;
                    end
                    a.found = done ? 1'b1
                        : (longint'(win_hi) - cur + 1 >= longint'(r.duration));
                    a.slot_start = TW'(cur);
                end
            end
            default: a = '0;
        endcase
        return a;
    endfunction

    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected beat %p", $time, out_data);
                errors++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (out_data.status !== want.status)
                begin
                    $display("%0t: status exp %0d got %0d", $time, want.status,
                             out_data.status);
                    errors++;
                end
                if (out_data.found !== want.found)
                begin
                    $display("%0t: found exp %0d got %0d", $time, want.found,
                             out_data.found);
                    errors++;
                end
                if (out_data.slot_start !== want.slot_start)
                begin
                    $display("%0t: slot_start exp %0d got %0d", $time,
                             want.slot_start, out_data.slot_start);
                    errors++;
                end
                if (out_data.position !== want.position)
                begin
                    $display("%0t: position exp %0d got %0d", $time, want.position,
                             out_data.position);
                    errors++;
                end
            end
        end
    end

    // The receiver stalls at random, or for a long stretch when asked to.
    initial
    begin
        int wait_n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_off) @(posedge clk);
                hold_off = 0;
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (wait_n > 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_n - 1) @(posedge clk);
            end
        end
    end

    task automatic send_request(in_beat_t r, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
        repeat (gap) @(posedge clk);
        in_valid <= 1'b1;
        in_data <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_answers.push_back(predict_answer(r));
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic request(logic [1:0] kind, int s, int e, int d);
        in_beat_t r;
        r.req_type = kind;
        r.start_time = TW'(s);
        r.end_time = TW'(e);
        r.duration = TW'(d);
        send_request(r);
    endtask

    task automatic drain();
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (ENTRIES + 10) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= TW'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_WIN_START: win_lo = TW'(value);
            CFG_WIN_END:   win_hi = TW'(value);
            default:       total_cap = TW'(value);
        endcase
        @(posedge clk);
    endtask

    task automatic clear_table();
        while (book_count > 0)
            request(REQ_REMOVE, book_start[$urandom_range(0, book_count - 1)], 0, 0);
    endtask

    task automatic test_directed();
        request(REQ_FIND, 0, 0, 0);
        request(REQ_FIND, 0, 0, 86400);
        request(REQ_FIND, 0, 0, 131071);
        request(REQ_REMOVE, 5, 0, 0);
        request(REQ_INSERT, 100, 199, 0);
        request(REQ_INSERT, 0, 0, 0);
        request(REQ_INSERT, 86399, 86399, 0);
        request(REQ_INSERT, 500, 400, 0);
        request(REQ_INSERT, 100, 150, 0);
        request(REQ_FIND, 0, 0, 50);
        request(REQ_FIND, 0, 0, 86000);
        request(REQ_FIND, 0, 0, 1);
        request(REQ_RESERVED, 131071, 131071, 131071);
        request(REQ_INSERT, 131071, 131071, 131071);
        request(REQ_REMOVE, 500, 0, 0);
        request(REQ_REMOVE, 100, 0, 0);
        request(REQ_REMOVE, 131071, 0, 0);
        request(REQ_INSERT, 0, 86399, 0);
        request(REQ_INSERT, 0, 86399, 0);
        request(REQ_FIND, 0, 0, 0);
        request(REQ_REMOVE, 0, 0, 0);
        request(REQ_REMOVE, 0, 0, 0);
        request(REQ_INSERT, 0, 131071, 0);
        request(REQ_FIND, 0, 0, 0);
        request(REQ_REMOVE, 0, 0, 0);
        clear_table();
        drain();
    endtask

    task automatic test_full_table();
        for (int i = 0; i < ENTRIES + 2; i++)
            request(REQ_INSERT, $urandom_range(0, 86399), $urandom_range(0, 86399), 0);
        request(REQ_FIND, 0, 0, $urandom_range(0, 100));
        clear_table();
        drain();
    endtask

    task automatic random_requests(int n);
        in_beat_t r;
        int       pick;
        for (int i = 0; i < n; i++)
        begin
            r = '0;
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                r.req_type = REQ_INSERT;
                r.start_time = ($urandom_range(0, 9) == 0) ? TW'($urandom)
                                                           : TW'($urandom_range(0, 86399));
                r.end_time = ($urandom_range(0, 7) == 0) ? TW'($urandom)
                    : TW'(r.start_time + $urandom_range(0, 3000));
            end
            else if (pick < 65)
            begin
                r.req_type = REQ_REMOVE;
                r.start_time = (book_count > 0 && pick < 60)
                    ? book_start[$urandom_range(0, book_count - 1)] : TW'($urandom);
            end
            else if (pick < 97)
            begin
                r.req_type = REQ_FIND;
                r.duration = ($urandom_range(0, 5) == 0) ? TW'($urandom)
                                                         : TW'($urandom_range(0, 5000));
            end
            else
            begin
                r.req_type = REQ_RESERVED;
            end
            if (r.req_type != REQ_FIND)
                r.duration = TW'($urandom);
            if (r.req_type != REQ_INSERT)
                r.end_time = TW'($urandom);
            send_request(r);
        end
        clear_table();
        drain();
    endtask

    task automatic test_settings();
        write_reg(CFG_WIN_START, 1000);
        write_reg(CFG_WIN_END, 50000);
        write_reg(CFG_MAX_TOTAL, 40000);
        random_requests(60);
        write_reg(CFG_WIN_START, 86399);
        write_reg(CFG_WIN_END, 0);
        write_reg(CFG_MAX_TOTAL, 0);
        random_requests(20);
        write_reg(CFG_WIN_START, 0);
        write_reg(CFG_WIN_END, 86399);
        write_reg(CFG_MAX_TOTAL, 131071);
        random_requests(100);
        write_reg(CFG_MAX_TOTAL, 86400);
    endtask

    task automatic test_backpressure();
        hold_off = 600;
        for (int i = 0; i < 12; i++)
        begin
            in_beat_t r;
            r = '0;
            r.req_type = REQ_FIND;
            r.duration = TW'($urandom_range(0, 2000));
            send_request(r, 1);
        end
        drain();
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        hold_off = 0;
        book_count = 0;
        booked_sum = '0;
        win_lo = '0;
        win_hi = 17'd86399;
        total_cap = 17'd86400;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_table();
        test_backpressure();
        random_requests(80);
        test_settings();
        drain();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
hdl/isff_pkg.sv
hdl/isff_cell.sv
hdl/interval_slot_first_fit_top.sv
sim/tb_interval_slot_first_fit_top.sv
